### src/deq_pkg.sv
package deq_pkg;

  // queue geometry
  localparam int DEPTH  = 8;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;
  localparam int OCC_W  = 4;

  // operation codes
  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } kind_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // control broadcast to every cell of the row
  typedef struct packed {
    logic                     ok;
    kind_t                    op;
    logic [CNT_W-1:0]         count;
    logic signed [DATA_W-1:0] push_value;
  } cell_ctrl_t;

endpackage

### src/deq_req_if.sv
interface deq_req_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output kind, output push_value, input ready);
  modport sink   (input valid, input kind, input push_value, output ready);
endinterface

### src/deq_rsp_if.sv
interface deq_rsp_if;
  import deq_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] pop_value;
  status_t                  status;
  logic [OCC_W-1:0]         occupancy;

  modport source (output valid, output pop_value, output status, output occupancy,
                  input ready);
  modport sink   (input valid, input pop_value, input status, input occupancy,
                  output ready);
endinterface

### src/deq_cell.sv
module deq_cell (
  input  logic                             clk,
  input  deq_pkg::cell_ctrl_t              ctrl,
  input  logic [deq_pkg::IDX_W-1:0]        idx,
  input  logic signed [deq_pkg::DATA_W-1:0] left_data,
  input  logic signed [deq_pkg::DATA_W-1:0] right_data,
  output logic signed [deq_pkg::DATA_W-1:0] data,
  output logic signed [deq_pkg::DATA_W-1:0] tap
);
  import deq_pkg::*;

  logic [CNT_W-1:0] here;
  logic             is_rear_slot;
  logic             is_last_entry;

  // position of this cell compared with the fill level
  assign here          = CNT_W'(idx);
  assign is_rear_slot  = (here == ctrl.count);
  assign is_last_entry = (here == ctrl.count - CNT_W'(1));

  // shift toward the rear on push front, toward the front on pop front; push rear writes the rear slot
  always_ff @(posedge clk) begin
    if (ctrl.ok) begin
      unique case (ctrl.op)
        OP_PUSH_FRONT: data <= left_data;
        OP_PUSH_REAR: begin
          if (is_rear_slot) begin
            data <= ctrl.push_value;
          end
        end
        OP_POP_FRONT:  data <= right_data;
        OP_POP_REAR:   ;
        default:       ;
      endcase
    end
  end

  // rear entry offered to the result mux
  assign tap = (ctrl.ok && ctrl.op == OP_POP_REAR && is_last_entry) ? data : '0;

endmodule

### src/double_ended_queue_core.sv
// a result word is registered as its request word is accepted
// throughput: one word per cycle; a request is taken whenever the result
// register is empty or its word is taken in the same cycle
// the entries sit in a row of cells that shift one place per push or pop front
// reset (synchronous, active high) empties the queue and drops any pending result
module double_ended_queue_core (
  input  logic      clk,
  input  logic      rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);
  import deq_pkg::*;

  logic [CNT_W-1:0]         count;
  logic [CNT_W-1:0]         count_next;
  logic                     take;
  logic                     is_full;
  logic                     is_empty;
  logic                     is_push;
  cell_ctrl_t               ctrl;
  status_t                  status_next;
  logic signed [DATA_W-1:0] pop_next;
  logic signed [DATA_W-1:0] rear_pick;

  logic signed [DATA_W-1:0] cell_data [DEPTH];
  logic signed [DATA_W-1:0] cell_tap  [DEPTH];

  // handshake: the result register parts the two sides
  assign req.ready = !rsp.valid || rsp.ready;
  assign take      = req.valid && req.ready;

  // full and empty checks
  assign is_full  = (count == CNT_W'(DEPTH));
  assign is_empty = (count == '0);
  assign is_push  = (req.kind == OP_PUSH_FRONT) || (req.kind == OP_PUSH_REAR);

  always_comb begin
    ctrl.op         = req.kind;
    ctrl.count      = count;
    ctrl.push_value = req.push_value;
    ctrl.ok         = take && (is_push ? !is_full : !is_empty);
  end

  // row of cells, cell 0 holds the front entry
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [DATA_W-1:0] left_in;
    logic signed [DATA_W-1:0] right_in;

    if (i == 0) begin : g_first
      assign left_in = req.push_value;
    end else begin : g_mid_l
      assign left_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in = '0;
    end else begin : g_mid_r
      assign right_in = cell_data[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .idx        (IDX_W'(i)),
      .left_data  (left_in),
      .right_data (right_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  // gather the rear entry from the cell taps
  always_comb begin
    rear_pick = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rear_pick = rear_pick | cell_tap[i];
    end
  end

  // status, popped value and next fill level
  always_comb begin
    status_next = ST_OK;
    pop_next    = '0;
    count_next  = count;
    unique case (req.kind)
      OP_PUSH_FRONT, OP_PUSH_REAR: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + CNT_W'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          pop_next   = cell_data[0];
          count_next = count - CNT_W'(1);
        end
      end
      OP_POP_REAR: begin
        if (is_empty) begin
          status_next = ST_EMPTY;
        end else begin
          pop_next   = rear_pick;
          count_next = count - CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  // fill level and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp.valid <= 1'b0;
    end else begin
      if (take) begin
        count     <= count_next;
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (take) begin
      rsp.pop_value <= pop_next;
      rsp.status    <= status_next;
      rsp.occupancy <= OCC_W'(count_next);
    end
  end

endmodule

### tb/deq_checker.sv
module deq_checker (
  input  logic clk,
  input  logic rst,
  deq_req_if   req,
  deq_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  typedef struct packed {
    logic signed [DATA_W-1:0] pop_value;
    status_t                  status;
    logic [OCC_W-1:0]         occupancy;
  } deq_result_t;

  // shadow copy of the queue contents
  logic signed [DATA_W-1:0] slot_mem [DEPTH];
  logic [IDX_W-1:0]         head_ptr;
  logic [IDX_W-1:0]         tail_ptr;
  int                       held;

  deq_result_t result_fifo [$];

  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] i);
    return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
  endfunction

  // apply one operation to the shadow deque and build the result word
  function automatic deq_result_t apply_deq_op(input kind_t op,
                                               input logic signed [DATA_W-1:0] val);
    deq_result_t r;
    r.pop_value = '0;
    r.status    = ST_OK;
    case (op)
      OP_PUSH_FRONT: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          head_ptr           = step_down(head_ptr);
          slot_mem[head_ptr] = val;
          held++;
        end
      end
      OP_PUSH_REAR: begin
        if (held >= DEPTH) begin
          r.status = ST_FULL;
        end else begin
          slot_mem[tail_ptr] = val;
          tail_ptr           = step_up(tail_ptr);
          held++;
        end
      end
      OP_POP_FRONT: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.pop_value = slot_mem[head_ptr];
          head_ptr    = step_up(head_ptr);
          held--;
        end
      end
      default: begin
        if (held == 0) begin
          r.status = ST_EMPTY;
        end else begin
          tail_ptr    = step_down(tail_ptr);
          r.pop_value = slot_mem[tail_ptr];
          held--;
        end
      end
    endcase
    r.occupancy = OCC_W'(held);
    return r;
  endfunction

  // watch both channels, predict on request words, compare on result words
  always @(posedge clk) begin : watch
    deq_result_t want;
    if (rst) begin
      head_ptr = '0;
      tail_ptr = '0;
      held     = 0;
      result_fifo.delete();
    end else begin
      if (req.valid && req.ready) begin
        result_fifo.push_back(apply_deq_op(req.kind, req.push_value));
      end
      if (rsp.valid && rsp.ready) begin
        if (result_fifo.size() == 0) begin
          fail_count++;
          $display("%0t: result word with none expected: got pop_value %0d",
                   $time, rsp.pop_value,
                   " status %0d occupancy %0d", rsp.status, rsp.occupancy);
        end else begin
          want = result_fifo.pop_front();
          if (rsp.pop_value !== want.pop_value) begin
            fail_count++;
            $display("%0t: pop_value mismatch: expected %0d got %0d",
                     $time, want.pop_value, rsp.pop_value);
          end
          if (rsp.status !== want.status) begin
            fail_count++;
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, want.status, rsp.status);
          end
          if (rsp.occupancy !== want.occupancy) begin
            fail_count++;
            $display("%0t: occupancy mismatch: expected %0d got %0d",
                     $time, want.occupancy, rsp.occupancy);
          end
        end
      end
    end
    pending <= result_fifo.size();
  end

endmodule

### tb/double_ended_queue_core_tb.sv
module double_ended_queue_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import deq_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_WORDS = 1000;
  localparam int HOLD_AT      = 400;
  localparam int LONG_HOLD    = 60;
  localparam int DRAIN_CYCLES = 10;

  localparam logic signed [DATA_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] VAL_MAX = 32'sh7fff_ffff;

  logic clk = 1'b0;
  logic rst;
  int   fail_count;
  int   pending;
  bit   sender_bursty = 1'b0;

  deq_req_if req_if ();
  deq_rsp_if rsp_if ();

  double_ended_queue_core u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  deq_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always #2 clk = ~clk;

  // offer one request word after a random gap (none when bursty), wait until it is taken
  task automatic send_word(input kind_t op, input logic signed [DATA_W-1:0] val);
    int gap;
    gap = sender_bursty ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid      <= 1'b1;
    req_if.kind       <= op;
    req_if.push_value <= val;
    do @(posedge clk); while (!(req_if.valid && req_if.ready));
  endtask

  // random data half the time, corner values the other half
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return VAL_MIN;
      1:       return VAL_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // request side: reset, directed words, then random traffic
  initial begin
    int push_pct;
    push_pct          = 50;
    req_if.valid      <= 1'b0;
    req_if.kind       <= OP_PUSH_FRONT;
    req_if.push_value <= '0;
    rst               <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // pops on an empty queue
    send_word(OP_POP_FRONT, 32'sd5);
    send_word(OP_POP_REAR, VAL_MIN);
    // front push wraps the head below zero, then single pops at each end
    send_word(OP_PUSH_FRONT, VAL_MAX);
    send_word(OP_PUSH_REAR, VAL_MIN);
    send_word(OP_POP_FRONT, '0);
    send_word(OP_POP_REAR, '1);
    // fill from both ends
    send_word(OP_PUSH_FRONT, '1);
    send_word(OP_PUSH_REAR, '0);
    send_word(OP_PUSH_FRONT, 32'sd1);
    send_word(OP_PUSH_REAR, 32'sh5555_5555);
    send_word(OP_PUSH_FRONT, 32'shaaaa_aaaa);
    send_word(OP_PUSH_REAR, VAL_MAX);
    send_word(OP_PUSH_FRONT, VAL_MIN);
    send_word(OP_PUSH_REAR, 32'sh1234_5678);
    // pushes refused when full
    send_word(OP_PUSH_FRONT, 32'sd7);
    send_word(OP_PUSH_REAR, 32'sd9);
    // drain from alternating ends
    repeat (4) begin
      send_word(OP_POP_REAR, $urandom);
      send_word(OP_POP_FRONT, $urandom);
    end
    send_word(OP_POP_REAR, '0);

    // random traffic, push bias changes so the queue swings empty to full
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 50;
          default: push_pct = 20;
        endcase
      end
      if (n % 64 == 0) sender_bursty = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 99) < push_pct) begin
        send_word($urandom_range(0, 1) ? OP_PUSH_REAR : OP_PUSH_FRONT, pick_value());
      end else begin
        send_word($urandom_range(0, 1) ? OP_POP_REAR : OP_POP_FRONT, pick_value());
      end
    end
    req_if.valid <= 1'b0;

    // drain outstanding results
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // result side: random stalls, quiet stretches and one long hold-off
  initial begin
    int  wait_cycles;
    int  taken;
    bit  held_long;
    bit  stalling;
    taken     = 0;
    held_long = 1'b0;
    stalling  = 1'b1;
    rsp_if.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 50 == 0) stalling = ($urandom_range(0, 3) != 0);
      if (!held_long && taken >= HOLD_AT) begin
        wait_cycles = LONG_HOLD;
        held_long   = 1'b1;
      end else begin
        wait_cycles = stalling ? $urandom_range(0, 5) : 0;
      end
      if (wait_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (!(rsp_if.valid && rsp_if.ready));
      taken++;
    end
  end

  // watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### double_ended_queue_core.f
src/deq_pkg.sv
src/deq_req_if.sv
src/deq_rsp_if.sv
src/deq_cell.sv
src/double_ended_queue_core.sv
tb/deq_checker.sv
tb/double_ended_queue_core_tb.sv
